@@ sv/tbi_pkg.sv @@
`timescale 1ns / 1ps
package tbi_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_BITS = 24;
    localparam int THR_BITS    = 32;
    localparam int APB_DATA_W  = 32;
    localparam int ADDR_W      = 3;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int MUL_W  = 2 * DOT_W;
    localparam int NUM_W  = MUL_W + 1;
    localparam int DEN_W  = MUL_W;
    localparam int DVD_W  = NUM_W + FRAC_BITS;
    localparam int QS_W   = DVD_W + 1;
    localparam int U_W    = QS_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ADDR_W-3:0] REG_THRESHOLD = '0;
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(1);

    localparam logic signed [U_W-1:0] ONE_FIX = U_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [NUM_W-1:0] nv;
        logic signed [NUM_W-1:0] nw;
        logic [DEN_W-1:0]        den;
    } tbi_work_t;

endpackage

@@ sv/tbi_if.sv @@
`timescale 1ns / 1ps
interface tbi_in_if;
    import tbi_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_a_z;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_b_z;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    logic signed [COORD_BITS-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

interface tbi_out_if;
    import tbi_pkg::*;
    logic valid;
    logic ready;
    logic signed [WEIGHT_BITS-1:0] weight_u;
    logic signed [WEIGHT_BITS-1:0] weight_v;
    logic signed [WEIGHT_BITS-1:0] weight_w;
    logic valid_res;
    logic inside_res;

    modport source (
        output valid, weight_u, weight_v, weight_w, valid_res, inside_res,
        input  ready
    );
    modport sink (
        input  valid, weight_u, weight_v, weight_w, valid_res, inside_res,
        output ready
    );
endinterface

@@ sv/triangle_barycentric_inside_test_top.sv @@
`timescale 1ns / 1ps
// Pipeline: 5 front stages, the queue, 89 restoring divider stages and 4 back stages.
// One item per cycle while neither side is stalled; both dividers are fully pipelined,
// one quotient bit per stage.
// A 2-entry queue separates the front from the back; each side stalls on its own.
// Reset (rst_n, asynchronous, active low) empties all stages and the queue
// and sets degenerate_threshold to 1.
module triangle_barycentric_inside_test_top (
    input  logic                             clk,
    input  logic                             rst_n,
    tbi_in_if.sink                           query,
    tbi_out_if.source                        result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbi_pkg::ADDR_W-1:0]       paddr,
    input  logic [tbi_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tbi_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tbi_pkg::*;

    logic [THR_BITS-1:0] thr_reg;
    logic      push_valid, push_ready, pop_valid, pop_ready;
    tbi_work_t push_data, pop_data;
    logic      hit;

    assign pready = 1'b1;
    assign hit    = paddr[ADDR_W-1:2] == REG_THRESHOLD;
    assign prdata = hit ? APB_DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESHOLD_RESET;
        else if (psel && penable && pwrite && hit)
            thr_reg <= pwdata[THR_BITS-1:0];
    end

    tbi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tbi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tbi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

@@ sv/tbi_front.sv @@
`timescale 1ns / 1ps
module tbi_front (
    input  logic              clk,
    input  logic              rst_n,
    tbi_in_if.sink            query,
    output logic              push_valid,
    input  logic              push_ready,
    output tbi_pkg::tbi_work_t push_data
);
    import tbi_pkg::*;

    logic front_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [COORD_BITS-1:0] p_reg [3];
    logic signed [COORD_BITS-1:0] a_reg [3];
    logic signed [COORD_BITS-1:0] b_reg [3];
    logic signed [COORD_BITS-1:0] c_reg [3];

    logic signed [DIFF_W-1:0] e0_reg [3];
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];

    logic signed [PROD_W-1:0] m00_reg [3];
    logic signed [PROD_W-1:0] m01_reg [3];
    logic signed [PROD_W-1:0] m11_reg [3];
    logic signed [PROD_W-1:0] m20_reg [3];
    logic signed [PROD_W-1:0] m21_reg [3];

    logic signed [DOT_W-1:0] d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;

    logic signed [MUL_W-1:0] den_a_reg, den_b_reg;
    logic signed [MUL_W-1:0] nv_a_reg, nv_b_reg, nw_a_reg, nw_b_reg;

    assign front_en    = !v5_reg || push_ready;
    assign query.ready = front_en;
    assign push_valid  = v5_reg;

    always_comb
    begin
        push_data.den = DEN_W'(den_a_reg - den_b_reg);
        push_data.nv  = NUM_W'(nv_a_reg) - NUM_W'(nv_b_reg);
        push_data.nw  = NUM_W'(nw_a_reg) - NUM_W'(nw_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (front_en)
        begin
            v1_reg <= query.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            p_reg[0] <= query.point_x;
            p_reg[1] <= query.point_y;
            p_reg[2] <= query.point_z;
            a_reg[0] <= query.vert_a_x;
            a_reg[1] <= query.vert_a_y;
            a_reg[2] <= query.vert_a_z;
            b_reg[0] <= query.vert_b_x;
            b_reg[1] <= query.vert_b_y;
            b_reg[2] <= query.vert_b_z;
            c_reg[0] <= query.vert_c_x;
            c_reg[1] <= query.vert_c_y;
            c_reg[2] <= query.vert_c_z;
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i]  <= DIFF_W'(b_reg[i]) - DIFF_W'(a_reg[i]);
                e1_reg[i]  <= DIFF_W'(c_reg[i]) - DIFF_W'(a_reg[i]);
                e2_reg[i]  <= DIFF_W'(p_reg[i]) - DIFF_W'(a_reg[i]);
                m00_reg[i] <= e0_reg[i] * e0_reg[i];
                m01_reg[i] <= e0_reg[i] * e1_reg[i];
                m11_reg[i] <= e1_reg[i] * e1_reg[i];
                m20_reg[i] <= e2_reg[i] * e0_reg[i];
                m21_reg[i] <= e2_reg[i] * e1_reg[i];
            end
            d00_reg <= DOT_W'(m00_reg[0]) + DOT_W'(m00_reg[1]) + DOT_W'(m00_reg[2]);
            d01_reg <= DOT_W'(m01_reg[0]) + DOT_W'(m01_reg[1]) + DOT_W'(m01_reg[2]);
            d11_reg <= DOT_W'(m11_reg[0]) + DOT_W'(m11_reg[1]) + DOT_W'(m11_reg[2]);
            d20_reg <= DOT_W'(m20_reg[0]) + DOT_W'(m20_reg[1]) + DOT_W'(m20_reg[2]);
            d21_reg <= DOT_W'(m21_reg[0]) + DOT_W'(m21_reg[1]) + DOT_W'(m21_reg[2]);
            den_a_reg <= d00_reg * d11_reg;
            den_b_reg <= d01_reg * d01_reg;
            nv_a_reg  <= d11_reg * d20_reg;
            nv_b_reg  <= d01_reg * d21_reg;
            nw_a_reg  <= d00_reg * d21_reg;
            nw_b_reg  <= d01_reg * d20_reg;
        end
    end

endmodule

@@ sv/tbi_queue.sv @@
`timescale 1ns / 1ps
module tbi_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tbi_pkg::tbi_work_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tbi_pkg::tbi_work_t pop_data
);
    import tbi_pkg::*;

    tbi_work_t mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
            if (pop)
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count lost a push");

endmodule

@@ sv/tbi_back.sv @@
`timescale 1ns / 1ps
module tbi_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tbi_pkg::THR_BITS-1:0]  threshold,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  tbi_pkg::tbi_work_t            pop_data,
    tbi_out_if.source                     result
);
    import tbi_pkg::*;

    typedef struct packed {
        logic             deg;
        logic             neg_v;
        logic             neg_w;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem_v;
        logic [DEN_W-1:0] rem_w;
        logic [DVD_W-1:0] q_v;
        logic [DVD_W-1:0] q_w;
    } div_t;

    function automatic div_t div_step(input div_t s);
        div_t r;
        logic [DEN_W:0] t_v, t_w;
        logic ge_v, ge_w;
        r = s;
        t_v = {s.rem_v, s.q_v[DVD_W-1]};
        t_w = {s.rem_w, s.q_w[DVD_W-1]};
        ge_v = t_v >= {1'b0, s.den};
        ge_w = t_w >= {1'b0, s.den};
        r.rem_v = ge_v ? DEN_W'(t_v - {1'b0, s.den}) : t_v[DEN_W-1:0];
        r.rem_w = ge_w ? DEN_W'(t_w - {1'b0, s.den}) : t_w[DEN_W-1:0];
        r.q_v = {s.q_v[DVD_W-2:0], ge_v};
        r.q_w = {s.q_w[DVD_W-2:0], ge_w};
        return r;
    endfunction

    function automatic logic signed [WEIGHT_BITS-1:0] sat(input logic signed [U_W-1:0] x);
        logic [U_W-WEIGHT_BITS-1:0] top;
        logic signed [WEIGHT_BITS-1:0] r;
        top = x[U_W-2:WEIGHT_BITS-1];
        if (!x[U_W-1] && (|top))
            r = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        else if (x[U_W-1] && !(&top))
            r = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
        else
            r = x[WEIGHT_BITS-1:0];
        return r;
    endfunction

    logic back_en;
    logic   vld_reg [DVD_W+1];
    div_t   st_reg  [DVD_W+1];
    div_t   load_next;
    logic [NUM_W-1:0] mag_v, mag_w;

    logic va_reg, vb_reg, vo_reg;
    logic deg_a_reg, deg_b_reg;
    logic signed [QS_W-1:0] sv_a_reg, sw_a_reg, sv_b_reg, sw_b_reg;
    logic signed [U_W-1:0]  su_b_reg;
    logic signed [WEIGHT_BITS-1:0] su_sat, sv_sat, sw_sat;
    logic signed [WEIGHT_BITS-1:0] wu_reg, wv_reg, ww_reg;
    logic valid_res_reg, inside_res_reg;

    assign back_en   = !vo_reg || result.ready;
    assign pop_ready = back_en;

    always_comb
    begin
        mag_v = pop_data.nv[NUM_W-1] ? NUM_W'(-pop_data.nv) : NUM_W'(pop_data.nv);
        mag_w = pop_data.nw[NUM_W-1] ? NUM_W'(-pop_data.nw) : NUM_W'(pop_data.nw);
        load_next.deg   = (pop_data.den == '0) || (pop_data.den < DEN_W'(threshold));
        load_next.neg_v = pop_data.nv[NUM_W-1];
        load_next.neg_w = pop_data.nw[NUM_W-1];
        load_next.den   = pop_data.den;
        load_next.rem_v = '0;
        load_next.rem_w = '0;
        load_next.q_v   = {mag_v, {FRAC_BITS{1'b0}}};
        load_next.q_w   = {mag_w, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DVD_W; k++)
                vld_reg[k] <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (back_en)
        begin
            vld_reg[0] <= pop_valid;
            for (int k = 1; k <= DVD_W; k++)
                vld_reg[k] <= vld_reg[k-1];
            va_reg <= vld_reg[DVD_W];
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            st_reg[0] <= load_next;
            for (int k = 1; k <= DVD_W; k++)
                st_reg[k] <= div_step(st_reg[k-1]);
            deg_a_reg <= st_reg[DVD_W].deg;
            sv_a_reg  <= st_reg[DVD_W].neg_v ? -QS_W'(st_reg[DVD_W].q_v)
                                             : QS_W'(st_reg[DVD_W].q_v);
            sw_a_reg  <= st_reg[DVD_W].neg_w ? -QS_W'(st_reg[DVD_W].q_w)
                                             : QS_W'(st_reg[DVD_W].q_w);
            deg_b_reg <= deg_a_reg;
            sv_b_reg  <= sv_a_reg;
            sw_b_reg  <= sw_a_reg;
            su_b_reg  <= ONE_FIX - U_W'(sv_a_reg) - U_W'(sw_a_reg);
            wu_reg    <= deg_b_reg ? '0 : su_sat;
            wv_reg    <= deg_b_reg ? '0 : sv_sat;
            ww_reg    <= deg_b_reg ? '0 : sw_sat;
            valid_res_reg  <= !deg_b_reg;
            inside_res_reg <= !deg_b_reg && !su_sat[WEIGHT_BITS-1]
                              && !sv_sat[WEIGHT_BITS-1] && !sw_sat[WEIGHT_BITS-1];
        end
    end

    always_comb
    begin
        su_sat = sat(su_b_reg);
        sv_sat = sat(U_W'(sv_b_reg));
        sw_sat = sat(U_W'(sw_b_reg));
    end

    assign result.valid      = vo_reg;
    assign result.weight_u   = wu_reg;
    assign result.weight_v   = wv_reg;
    assign result.weight_w   = ww_reg;
    assign result.valid_res  = valid_res_reg;
    assign result.inside_res = inside_res_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.valid_res) |-> (result.weight_u == '0
            && result.weight_v == '0 && result.weight_w == '0 && !result.inside_res))
        else $error("degenerate item carries nonzero weights");

    a_inside_signs: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.inside_res) |-> (result.valid_res
            && !result.weight_u[WEIGHT_BITS-1] && !result.weight_v[WEIGHT_BITS-1]
            && !result.weight_w[WEIGHT_BITS-1]))
        else $error("inside flag with a negative weight");

    a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> vld_reg[0])
        else $error("popped item lost at divider entry");

endmodule
